// ===== design/trcg_pkg.sv =====
package trcg_pkg;

  localparam int SCREEN_WIDTH_DEF  = 240;
  localparam int SCREEN_HEIGHT_DEF = 320;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE = 3'd4;

  localparam logic [15:0] FG_COLOR_RST    = 16'hFFFF;
  localparam logic [7:0]  PIXEL_SCALE_RST = 8'd1;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam logic [2:0] COL_SPACER = 3'd5;
  localparam logic [2:0] ROW_LAST   = 3'd6;

  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic        halted;
  } cursor_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  w;
    logic [10:0] h;
  } rect_req_t;

  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic        visible;
  } rect_clip_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DRAW,
    ST_UPDATE
  } gen_state_t;

  // Five column bytes, column 0 in the top byte; bit n of a byte is glyph row n.
  function automatic logic [39:0] glyph_bits(input logic [7:0] code);
    logic [7:0]  c;
    logic [39:0] g;
    c = code;
    if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
      c = code - CASE_OFFSET;
    end
    case (c)
      8'h30: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      8'h31: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      8'h32: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      8'h33: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      8'h34: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      8'h35: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      8'h36: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      8'h37: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h39: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      8'h42: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h43: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      8'h44: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      8'h45: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      8'h46: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
      8'h47: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
      8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      8'h4A: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
      8'h4B: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      8'h4C: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      8'h4E: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
      8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      8'h50: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      8'h51: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
      8'h52: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      8'h53: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      8'h57: g = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
      8'h58: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      8'h59: g = {8'h03, 8'h04, 8'h78, 8'h04, 8'h03};
      8'h5A: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
      8'h3A: g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      8'h2E: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      8'h2D: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      8'h2F: g = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
      8'h21: g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== design/trcg_ram.sv =====
module trcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/trcg_clip.sv =====
module trcg_clip #(
  parameter int SCREEN_WIDTH  = trcg_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = trcg_pkg::SCREEN_HEIGHT_DEF
) (
  input  trcg_pkg::rect_req_t  req,
  output trcg_pkg::rect_clip_t clip
);

  localparam logic [16:0] W17 = 17'(SCREEN_WIDTH);
  localparam logic [16:0] H17 = 17'(SCREEN_HEIGHT);
  localparam logic [15:0] W_MAX = 16'(SCREEN_WIDTH - 1);
  localparam logic [15:0] H_MAX = 16'(SCREEN_HEIGHT - 1);

  logic [16:0] x_end;
  logic [16:0] y_end;
  logic        on_screen;

  assign x_end     = {1'b0, req.x} + 17'(req.w) - 17'd1;
  assign y_end     = {1'b0, req.y} + 17'(req.h) - 17'd1;
  assign on_screen = ({1'b0, req.x} < W17) && ({1'b0, req.y} < H17);

  always_comb begin
    clip = '0;
    if (on_screen) begin
      clip.x0      = req.x;
      clip.y0      = req.y;
      clip.x1      = (x_end >= W17) ? W_MAX : x_end[15:0];
      clip.y1      = (y_end >= H17) ? H_MAX : y_end[15:0];
      clip.visible = 1'b1;
    end
  end

endmodule

// ===== design/text_to_rect_char_generator_unit.sv =====
// 5x7 text character generator: each drawn character becomes 36 clipped
// rectangle-fill transactions (35 glyph dots column by column, then a spacer
// column, last set on the spacer). Characters are taken one at a time; a drawn
// character occupies the block from the cursor read out of the state memory,
// through 36 rectangles at one per cycle via the single clip datapath while
// the output side does not stall, to the cursor write-back. Newline, string
// end and characters dropped while halted produce no transaction. The output
// register holds a finished rectangle while the next is prepared.
// Configuration writes are always ready and belong between strings.
module text_to_rect_char_generator_unit #(
  parameter int SCREEN_WIDTH  = trcg_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = trcg_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_char_code,
  input  logic                           in_new_string,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_rect_x0,
  output logic [15:0]                    out_rect_y0,
  output logic [15:0]                    out_rect_x1,
  output logic [15:0]                    out_rect_y1,
  output logic [15:0]                    out_rect_color,
  output logic                           out_visible,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [trcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  localparam logic [15:0] COL_WRAP = 16'(SCREEN_WIDTH - 6);
  localparam logic [15:0] ROW_STOP = 16'(SCREEN_HEIGHT - 8);
  localparam int          CUR_W    = $bits(trcg_pkg::cursor_t);

  logic [15:0] origin_x_r, origin_y_r, fg_color_r, bg_color_r;
  logic [7:0]  pixel_scale_r;

  trcg_pkg::gen_state_t state_r, state_nxt;
  logic        st_valid_r, st_valid_nxt;
  logic [7:0]  char_r, char_nxt;
  logic        new_str_r, new_str_nxt;
  logic [15:0] cur_col_r, cur_col_nxt;
  logic [15:0] cur_row_r, cur_row_nxt;
  logic [7:0]  scale_r, scale_nxt;
  logic [10:0] h7_r, h7_nxt;
  logic [39:0] glyph_r, glyph_nxt;
  logic [2:0]  col_idx_r, col_idx_nxt;
  logic [2:0]  row_idx_r, row_idx_nxt;
  logic [15:0] px_r, px_nxt;
  logic [15:0] py_r, py_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_x0_r, out_y0_r, out_x1_r, out_y1_r, out_color_r;
  logic        out_visible_r, out_last_r;
  logic        out_load;

  logic                 ram_we;
  trcg_pkg::cursor_t    ram_wdata;
  logic [CUR_W-1:0]     ram_rdata;
  trcg_pkg::cursor_t    cur_in;
  trcg_pkg::cursor_t    cur_ld;

  logic [7:0]  s_eff;
  logic [10:0] s_eff8;
  logic [10:0] s_r6;
  logic [10:0] s_r8;
  logic [15:0] upd_col;
  logic [15:0] upd_row;

  trcg_pkg::rect_req_t  req;
  trcg_pkg::rect_clip_t clip;
  logic [7:0]           col_byte;
  logic [15:0]          rect_color;
  logic                 is_spacer;

  trcg_ram #(
    .WIDTH(CUR_W),
    .DEPTH(1)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(1'b0),
    .wdata(ram_wdata),
    .raddr(1'b0),
    .rdata(ram_rdata)
  );

  trcg_clip #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_clip (
    .req (req),
    .clip(clip)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      fg_color_r    <= trcg_pkg::FG_COLOR_RST;
      bg_color_r    <= '0;
      pixel_scale_r <= trcg_pkg::PIXEL_SCALE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        trcg_pkg::CFG_ORIGIN_X:    origin_x_r    <= cfg_data;
        trcg_pkg::CFG_ORIGIN_Y:    origin_y_r    <= cfg_data;
        trcg_pkg::CFG_FG_COLOR:    fg_color_r    <= cfg_data;
        trcg_pkg::CFG_BG_COLOR:    bg_color_r    <= cfg_data;
        trcg_pkg::CFG_PIXEL_SCALE: pixel_scale_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Cursor entry reads as zero until first written.
  assign cur_in = st_valid_r ? trcg_pkg::cursor_t'(ram_rdata) : '0;
  assign s_eff  = (pixel_scale_r == 8'd0) ? 8'd1 : pixel_scale_r;
  assign s_eff8 = {s_eff, 3'b000};
  assign s_r6   = {1'b0, scale_r, 2'b00} + {2'b00, scale_r, 1'b0};
  assign s_r8   = {scale_r, 3'b000};

  assign is_spacer = (col_idx_r == trcg_pkg::COL_SPACER);

  always_comb begin
    case (col_idx_r)
      3'd0:    col_byte = glyph_r[39:32];
      3'd1:    col_byte = glyph_r[31:24];
      3'd2:    col_byte = glyph_r[23:16];
      3'd3:    col_byte = glyph_r[15:8];
      3'd4:    col_byte = glyph_r[7:0];
      default: col_byte = '0;
    endcase
  end

  always_comb begin
    req.x = px_r;
    req.y = is_spacer ? cur_row_r : py_r;
    req.w = scale_r;
    req.h = is_spacer ? h7_r : 11'(scale_r);
    if (is_spacer) begin
      rect_color = bg_color_r;
    end else begin
      rect_color = col_byte[row_idx_r] ? fg_color_r : bg_color_r;
    end
  end

  always_comb begin
    upd_col = cur_col_r + 16'(s_r6);
    upd_row = cur_row_r;
    if (upd_col >= COL_WRAP) begin
      upd_col = origin_x_r;
      upd_row = cur_row_r + 16'(s_r8);
    end
  end

  assign out_load = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    st_valid_nxt  = st_valid_r;
    char_nxt      = char_r;
    new_str_nxt   = new_str_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    scale_nxt     = scale_r;
    h7_nxt        = h7_r;
    glyph_nxt     = glyph_r;
    col_idx_nxt   = col_idx_r;
    row_idx_nxt   = row_idx_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_wdata     = cur_in;
    in_stall      = 1'b1;

    cur_ld = cur_in;
    if (new_str_r) begin
      cur_ld.col    = origin_x_r;
      cur_ld.row    = origin_y_r;
      cur_ld.halted = 1'b0;
    end

    unique case (state_r)
      trcg_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          char_nxt    = in_char_code;
          new_str_nxt = in_new_string;
          state_nxt   = trcg_pkg::ST_LOAD;
        end
      end
      trcg_pkg::ST_LOAD: begin
        if (cur_ld.halted) begin
          ram_we    = 1'b1;
          ram_wdata = cur_ld;
          state_nxt = trcg_pkg::ST_IDLE;
        end else if (char_r == trcg_pkg::CHAR_NUL) begin
          ram_we           = 1'b1;
          ram_wdata        = cur_ld;
          ram_wdata.halted = 1'b1;
          state_nxt        = trcg_pkg::ST_IDLE;
        end else if (char_r == trcg_pkg::CHAR_NEWLINE) begin
          ram_we        = 1'b1;
          ram_wdata     = cur_ld;
          ram_wdata.col = origin_x_r;
          ram_wdata.row = cur_ld.row + 16'(s_eff8);
          state_nxt     = trcg_pkg::ST_IDLE;
        end else begin
          cur_col_nxt = cur_ld.col;
          cur_row_nxt = cur_ld.row;
          px_nxt      = cur_ld.col;
          py_nxt      = cur_ld.row;
          scale_nxt   = s_eff;
          h7_nxt      = s_eff8 - 11'(s_eff);
          glyph_nxt   = trcg_pkg::glyph_bits(char_r);
          col_idx_nxt = '0;
          row_idx_nxt = '0;
          state_nxt   = trcg_pkg::ST_DRAW;
        end
        if (ram_we) begin
          st_valid_nxt = 1'b1;
        end
      end
      trcg_pkg::ST_DRAW: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (is_spacer) begin
            state_nxt = trcg_pkg::ST_UPDATE;
          end else if (row_idx_r == trcg_pkg::ROW_LAST) begin
            row_idx_nxt = '0;
            col_idx_nxt = col_idx_r + 3'd1;
            px_nxt      = px_r + 16'(scale_r);
            py_nxt      = cur_row_r;
          end else begin
            row_idx_nxt = row_idx_r + 3'd1;
            py_nxt      = py_r + 16'(scale_r);
          end
        end
      end
      trcg_pkg::ST_UPDATE: begin
        ram_we           = 1'b1;
        ram_wdata.col    = upd_col;
        ram_wdata.row    = upd_row;
        ram_wdata.halted = (upd_row >= ROW_STOP);
        st_valid_nxt     = 1'b1;
        state_nxt        = trcg_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = trcg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trcg_pkg::ST_IDLE;
      st_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_valid_r  <= st_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r    <= char_nxt;
    new_str_r <= new_str_nxt;
    cur_col_r <= cur_col_nxt;
    cur_row_r <= cur_row_nxt;
    scale_r   <= scale_nxt;
    h7_r      <= h7_nxt;
    glyph_r   <= glyph_nxt;
    col_idx_r <= col_idx_nxt;
    row_idx_r <= row_idx_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    if (state_r == trcg_pkg::ST_DRAW && out_load) begin
      out_x0_r      <= clip.x0;
      out_y0_r      <= clip.y0;
      out_x1_r      <= clip.x1;
      out_y1_r      <= clip.y1;
      out_color_r   <= clip.visible ? rect_color : 16'd0;
      out_visible_r <= clip.visible;
      out_last_r    <= is_spacer;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rect_x0    = out_x0_r;
  assign out_rect_y0    = out_y0_r;
  assign out_rect_x1    = out_x1_r;
  assign out_rect_y1    = out_y1_r;
  assign out_rect_color = out_color_r;
  assign out_visible    = out_visible_r;
  assign out_last       = out_last_r;

endmodule

// ===== design/trcg_checker.sv =====
module trcg_checker #(
  parameter int SCREEN_WIDTH  = trcg_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = trcg_pkg::SCREEN_HEIGHT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_rect_x0,
  input logic [15:0] out_rect_y0,
  input logic [15:0] out_rect_x1,
  input logic [15:0] out_rect_y1,
  input logic [15:0] out_rect_color,
  input logic        out_visible,
  input logic        out_last
);

  localparam logic [15:0] W16 = 16'(SCREEN_WIDTH);
  localparam logic [15:0] H16 = 16'(SCREEN_HEIGHT);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rect_x0) && $stable(out_rect_y0)
      && $stable(out_rect_x1) && $stable(out_rect_y1) && $stable(out_rect_color)
      && $stable(out_visible) && $stable(out_last))
    else $error("stalled result transaction changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous character in progress");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_visible |-> out_rect_x0 == 16'd0 && out_rect_y0 == 16'd0
      && out_rect_x1 == 16'd0 && out_rect_y1 == 16'd0 && out_rect_color == 16'd0)
    else $error("invisible rectangle carries nonzero fields");

  a_clip_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_visible |-> out_rect_x0 <= out_rect_x1 && out_rect_x1 < W16
      && out_rect_y0 <= out_rect_y1 && out_rect_y1 < H16)
    else $error("visible rectangle outside screen");

endmodule

bind text_to_rect_char_generator_unit trcg_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH),
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_trcg_checker (.*);
